// File: rtl/ccev_pkg.sv
// Shared widths, event codes and record types of the controller change event generator.
package ccev_pkg;

    localparam int MASK_W     = 17;
    localparam int TRIG_W     = 8;
    localparam int ID_W       = 8;
    localparam int TID_W      = 7;
    localparam int POS_W      = 16;
    localparam int SLOT_MAX   = 2;
    localparam int SLOT_IDX_W = $clog2(SLOT_MAX);
    localparam int KIND_W     = 2;
    localparam int BIDX_W     = 5;

    // Event slots of one record: buttons, then L2, then R2, then touch slots.
    localparam int EVT_SLOTS = MASK_W + 2 + SLOT_MAX;
    localparam int EVT_IDX_W = $clog2(EVT_SLOTS);
    localparam int LT_POS    = MASK_W;
    localparam int RT_POS    = MASK_W + 1;
    localparam int TCH_POS   = MASK_W + 2;

    localparam logic [KIND_W-1:0] KIND_BUTTON = 2'd0;
    localparam logic [KIND_W-1:0] KIND_LTRIG  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_RTRIG  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_TOUCH  = 2'd3;

    localparam logic [TRIG_W-1:0] LEVEL_PRESSED  = 8'hFF;
    localparam logic [TRIG_W-1:0] LEVEL_RELEASED = 8'h00;

    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // One classified snapshot, as handed from the front part to the back part.
    typedef struct packed {
        logic [MASK_W-1:0]                  btn_chg;
        logic [MASK_W-1:0]                  btn_now;
        logic                               lt_chg;
        logic                               rt_chg;
        logic [TRIG_W-1:0]                  lt;
        logic [TRIG_W-1:0]                  rt;
        logic [SLOT_MAX-1:0]                tch_vld;
        logic [SLOT_MAX-1:0]                tch_down;
        logic [SLOT_MAX-1:0][TID_W-1:0]     tch_id;
        logic [SLOT_MAX-1:0][POS_W-1:0]     tch_x;
        logic [SLOT_MAX-1:0][POS_W-1:0]     tch_y;
    } t_chg_rec;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    typedef struct packed {
        logic busy;
    } t_back_stat;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [BIDX_W-1:0] bidx;
        logic [TRIG_W-1:0] level;
        logic              down;
        logic [TID_W-1:0]  tid;
        logic [POS_W-1:0]  x;
        logic [POS_W-1:0]  y;
        logic              last;
    } t_event;

endpackage

// File: rtl/ccev_if.sv
// Handshake interfaces for the snapshot request channel and the event request channel.
interface ccev_snap_if
    import ccev_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic [MASK_W-1:0]        button_mask;
    logic [TRIG_W-1:0]        left_trigger;
    logic [TRIG_W-1:0]        right_trigger;
    logic signed [ID_W-1:0]   touch0_id;
    logic [POS_W-1:0]         touch0_x;
    logic [POS_W-1:0]         touch0_y;
    logic signed [ID_W-1:0]   touch1_id;
    logic [POS_W-1:0]         touch1_x;
    logic [POS_W-1:0]         touch1_y;

    modport source (
        output valid, button_mask, left_trigger, right_trigger,
               touch0_id, touch0_x, touch0_y, touch1_id, touch1_x, touch1_y,
        input  ready
    );
    modport sink (
        input  valid, button_mask, left_trigger, right_trigger,
               touch0_id, touch0_x, touch0_y, touch1_id, touch1_x, touch1_y,
        output ready
    );
endinterface

interface ccev_evt_if
    import ccev_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] event_kind;
    logic [BIDX_W-1:0] button_index;
    logic [TRIG_W-1:0] level;
    logic              touch_down;
    logic [TID_W-1:0]  touch_id;
    logic [POS_W-1:0]  touch_x;
    logic [POS_W-1:0]  touch_y;
    logic              last;

    modport source (
        output valid, event_kind, button_index, level, touch_down,
               touch_id, touch_x, touch_y, last,
        input  ready
    );
    modport sink (
        input  valid, event_kind, button_index, level, touch_down,
               touch_id, touch_x, touch_y, last,
        output ready
    );
endinterface

// File: rtl/controller_change_event_generator_unit.sv
// Top level of the controller change event generator: front part, record queue, back part.
//
// The block takes one controller snapshot per request on i_snap (button mask, L2 and R2
// levels, two touch slots) and compares it with the snapshot accepted before it. Each
// difference leaves as one event request on o_evt: changed buttons in index order, then
// L2, then R2, then one touch event per slot. The final event of a snapshot has last set;
// a snapshot that changes nothing gives no event at all.
// The front part classifies a snapshot in the cycle it is accepted and writes a change
// record into a two-entry queue. The back part sends one event per cycle from the record
// it holds while the receiver keeps taking them, so a snapshot with n changes (1 to 21)
// gives n events. The first event of a snapshot passes the queue, the pending register of
// the back part and the output register before it shows on o_evt. i_snap.ready is high
// whenever the queue has room, so snapshots are taken every cycle as long as the back part
// keeps up; the queue depth and the event count set the throughput. The event is held in
// an output register: while the receiver stalls it stays on o_evt, the back part waits, then
// the queue fills and i_snap.ready drops. After reset the stored snapshot is all released,
// both triggers zero and both touch slots empty; the queue and output register are empty.
module controller_change_event_generator_unit
    import ccev_pkg::*;
#(
    parameter int BUTTON_COUNT = 17,
    parameter int TOUCH_SLOTS  = 2
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ccev_snap_if.sink  i_snap,
    ccev_evt_if.source o_evt
);

    logic       push;
    logic       pop;
    t_chg_rec   rec_in;
    t_chg_rec   rec_head;
    t_q_stat    q_stat;
    t_back_stat back_stat;

    // Snapshot comparison and the stored previous snapshot.
    ccev_front #(
        .BUTTON_COUNT (BUTTON_COUNT),
        .TOUCH_SLOTS  (TOUCH_SLOTS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_snap   (i_snap),
        .i_q_stat (q_stat),
        .o_push   (push),
        .o_rec    (rec_in)
    );

    // Decouples snapshot acceptance from event delivery.
    ccev_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_rec   (rec_in),
        .i_pop   (pop),
        .o_head  (rec_head),
        .o_stat  (q_stat)
    );

    // Event sequencer with its output register.
    ccev_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (rec_head),
        .i_q_stat (q_stat),
        .o_pop    (pop),
        .o_evt    (o_evt),
        .o_stat   (back_stat)
    );

    // A record is never written into a full queue.
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> !q_stat.full)
        else $error("change record written into a full queue");

    // The output register is empty right after reset.
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_evt.valid)
        else $error("event request pending after reset");

    // An event without last means more changes of the same snapshot are still pending.
    a_more_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_evt.valid && o_evt.ready && !o_evt.last) |-> back_stat.busy)
        else $error("non-final event with no pending change behind it");

    // Button events carry only the pressed or released level.
    a_button_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_evt.valid && (o_evt.event_kind == KIND_BUTTON))
        |-> ((o_evt.level == LEVEL_PRESSED) || (o_evt.level == LEVEL_RELEASED)))
        else $error("button event with an invalid level");

endmodule

// File: rtl/ccev_front.sv
// Front part: accepts snapshots, compares them with the stored one and builds change records.
module ccev_front
    import ccev_pkg::*;
#(
    parameter int BUTTON_COUNT = 17,
    parameter int TOUCH_SLOTS  = 2
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ccev_snap_if.sink  i_snap,
    input  t_q_stat    i_q_stat,
    output logic       o_push,
    output t_chg_rec   o_rec
);

    logic [MASK_W-1:0] r_prev_mask;
    logic [TRIG_W-1:0] r_prev_lt;
    logic [TRIG_W-1:0] r_prev_rt;
    logic [ID_W-1:0]   r_prev_id [SLOT_MAX];
    logic [POS_W-1:0]  r_prev_x  [SLOT_MAX];
    logic [POS_W-1:0]  r_prev_y  [SLOT_MAX];

    logic [ID_W-1:0]   snap_id [SLOT_MAX];
    logic [POS_W-1:0]  snap_x  [SLOT_MAX];
    logic [POS_W-1:0]  snap_y  [SLOT_MAX];
    logic [MASK_W-1:0] btn_use;
    logic              accept;
    logic              any_chg;

    assign i_snap.ready = !i_q_stat.full;
    assign accept       = i_snap.valid && i_snap.ready;

    always_comb begin
        logic id_chg;
        logic rel;
        logic press;
        snap_id[0] = i_snap.touch0_id;
        snap_x[0]  = i_snap.touch0_x;
        snap_y[0]  = i_snap.touch0_y;
        snap_id[1] = i_snap.touch1_id;
        snap_x[1]  = i_snap.touch1_x;
        snap_y[1]  = i_snap.touch1_y;

        for (int b = 0; b < MASK_W; b++) begin
            btn_use[b] = (b < BUTTON_COUNT);
        end

        o_rec         = '0;
        o_rec.btn_chg = (r_prev_mask ^ i_snap.button_mask) & btn_use;
        o_rec.btn_now = i_snap.button_mask;
        o_rec.lt_chg  = (r_prev_lt != i_snap.left_trigger);
        o_rec.rt_chg  = (r_prev_rt != i_snap.right_trigger);
        o_rec.lt      = i_snap.left_trigger;
        o_rec.rt      = i_snap.right_trigger;

        for (int s = 0; s < SLOT_MAX; s++) begin
            // A release of a valid old finger takes precedence over a new press.
            id_chg = (r_prev_id[s] != snap_id[s]);
            rel    = id_chg && !r_prev_id[s][ID_W-1];
            press  = !rel && !snap_id[s][ID_W-1]
                     && (id_chg || (r_prev_x[s] != snap_x[s]) || (r_prev_y[s] != snap_y[s]));
            if (s < TOUCH_SLOTS) begin
                o_rec.tch_vld[s]  = rel || press;
                o_rec.tch_down[s] = press;
                o_rec.tch_id[s]   = rel ? r_prev_id[s][TID_W-1:0] : snap_id[s][TID_W-1:0];
                o_rec.tch_x[s]    = rel ? r_prev_x[s] : snap_x[s];
                o_rec.tch_y[s]    = rel ? r_prev_y[s] : snap_y[s];
            end
        end

        any_chg = (|o_rec.btn_chg) || o_rec.lt_chg || o_rec.rt_chg || (|o_rec.tch_vld);
        o_push  = accept && any_chg;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_mask <= '0;
            r_prev_lt   <= '0;
            r_prev_rt   <= '0;
            for (int s = 0; s < SLOT_MAX; s++) begin
                r_prev_id[s] <= '1;
                r_prev_x[s]  <= '0;
                r_prev_y[s]  <= '0;
            end
        end else if (accept) begin
            r_prev_mask <= i_snap.button_mask;
            r_prev_lt   <= i_snap.left_trigger;
            r_prev_rt   <= i_snap.right_trigger;
            for (int s = 0; s < SLOT_MAX; s++) begin
                r_prev_id[s] <= snap_id[s];
                r_prev_x[s]  <= snap_x[s];
                r_prev_y[s]  <= snap_y[s];
            end
        end
    end

endmodule

// File: rtl/ccev_queue.sv
// Short queue of change records between the front part and the back part.
module ccev_queue
    import ccev_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    input  t_chg_rec i_rec,
    input  logic     i_pop,
    output t_chg_rec o_head,
    output t_q_stat  o_stat
);

    t_chg_rec          r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_cnt;

    assign o_head       = r_mem[r_rd_ptr];
    assign o_stat.full  = (r_cnt == QCNT_W'(QDEPTH));
    assign o_stat.empty = (r_cnt == '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// File: rtl/ccev_back.sv
// Back part: walks the pending changes of one record, one event per cycle unless o_evt stalls.
module ccev_back
    import ccev_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_chg_rec    i_head,
    input  t_q_stat     i_q_stat,
    output logic        o_pop,
    ccev_evt_if.source  o_evt,
    output t_back_stat  o_stat
);

    t_chg_rec             r_cur;
    logic [EVT_SLOTS-1:0] r_pend;
    logic                 r_out_vld;
    t_event               r_evt;

    logic                  out_free;
    logic                  emit;
    logic [EVT_IDX_W-1:0]  sel_idx;
    logic [EVT_SLOTS-1:0]  sel_1h;
    logic [EVT_SLOTS-1:0]  pend_after;
    logic [EVT_SLOTS-1:0]  n_pend;
    logic [SLOT_IDX_W-1:0] slot;
    t_event                n_evt;

    always_comb begin
        // Lowest pending change goes first.
        sel_idx = '0;
        for (int k = EVT_SLOTS - 1; k >= 0; k--) begin
            if (r_pend[k]) begin
                sel_idx = EVT_IDX_W'(k);
            end
        end
        sel_1h     = EVT_SLOTS'(1) << sel_idx;
        out_free   = !r_out_vld || o_evt.ready;
        emit       = out_free && (|r_pend);
        pend_after = emit ? (r_pend & ~sel_1h) : r_pend;
        o_pop      = (pend_after == '0) && !i_q_stat.empty;
        n_pend     = o_pop ? {i_head.tch_vld, i_head.rt_chg, i_head.lt_chg, i_head.btn_chg}
                           : pend_after;

        slot  = SLOT_IDX_W'(sel_idx - EVT_IDX_W'(TCH_POS));
        n_evt = '0;
        if (sel_idx < EVT_IDX_W'(LT_POS)) begin
            n_evt.kind  = KIND_BUTTON;
            n_evt.bidx  = BIDX_W'(sel_idx);
            n_evt.level = r_cur.btn_now[sel_idx] ? LEVEL_PRESSED : LEVEL_RELEASED;
        end else if (sel_idx == EVT_IDX_W'(LT_POS)) begin
            n_evt.kind  = KIND_LTRIG;
            n_evt.level = r_cur.lt;
        end else if (sel_idx == EVT_IDX_W'(RT_POS)) begin
            n_evt.kind  = KIND_RTRIG;
            n_evt.level = r_cur.rt;
        end else begin
            n_evt.kind = KIND_TOUCH;
            n_evt.down = r_cur.tch_down[slot];
            n_evt.tid  = r_cur.tch_id[slot];
            n_evt.x    = r_cur.tch_x[slot];
            n_evt.y    = r_cur.tch_y[slot];
        end
        n_evt.last = (pend_after == '0);
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cur <= i_head;
        end
        if (emit) begin
            r_evt <= n_evt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend    <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_pend <= n_pend;
            if (emit) begin
                r_out_vld <= 1'b1;
            end else if (o_evt.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign o_stat.busy        = |r_pend;
    assign o_evt.valid        = r_out_vld;
    assign o_evt.event_kind   = r_evt.kind;
    assign o_evt.button_index = r_evt.bidx;
    assign o_evt.level        = r_evt.level;
    assign o_evt.touch_down   = r_evt.down;
    assign o_evt.touch_id     = r_evt.tid;
    assign o_evt.touch_x      = r_evt.x;
    assign o_evt.touch_y      = r_evt.y;
    assign o_evt.last         = r_evt.last;

endmodule
